FILE: design/montgomery_curve_ladder_scalar_mult_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Montgomery ladder block
// Concurrent checks on clk, disabled while arst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef MONTGOMERY_CURVE_LADDER_SCALAR_MULT_MACROS_SVH
`define MONTGOMERY_CURVE_LADDER_SCALAR_MULT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MCL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// next-cycle implication
`define MCL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define MCL_ASSERT_IMP(lbl, ante, cons)
`define MCL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: design/mcl_pkg.sv
// ----------------------------------------------------------------------------
// mcl_pkg
// Types, register map and ladder microprogram for the Montgomery ladder block.
// ----------------------------------------------------------------------------
package mcl_pkg;

	// width of one slice cell of the modular datapath
	localparam int CELL_W = 8;
	// width of raw operands, and bits walked by a multiply or reduce
	localparam int RAW_W  = 64;
	localparam int STEP_W = 6;

	// operand store
	localparam int RF_DEPTH = 16;
	localparam int RF_AW    = 4;

	// micro-operations
	typedef enum logic [2:0] {
		OP_RED = 3'd0,
		OP_MUL = 3'd1,
		OP_ADD = 3'd2,
		OP_SUB = 3'd3,
		OP_CPY = 3'd4
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [RF_AW-1:0] dst;
		logic [RF_AW-1:0] sa;
		logic [RF_AW-1:0] sb;
	} uop_t;

	// logical operand addresses; PD is the point being doubled, PS the other
	localparam logic [RF_AW-1:0] A_BX  = 4'd0;
	localparam logic [RF_AW-1:0] A_BZ  = 4'd1;
	localparam logic [RF_AW-1:0] A_D   = 4'd2;
	localparam logic [RF_AW-1:0] A_PDX = 4'd3;
	localparam logic [RF_AW-1:0] A_PDZ = 4'd4;
	localparam logic [RF_AW-1:0] A_PSX = 4'd5;
	localparam logic [RF_AW-1:0] A_PSZ = 4'd6;
	localparam logic [RF_AW-1:0] A_T0  = 4'd7;
	localparam logic [RF_AW-1:0] A_T1  = 4'd8;
	localparam logic [RF_AW-1:0] A_T2  = 4'd9;
	localparam logic [RF_AW-1:0] A_T3  = 4'd10;
	localparam logic [RF_AW-1:0] A_T4  = 4'd11;
	localparam logic [RF_AW-1:0] A_T5  = 4'd12;

	// physical homes of the ladder pair
	localparam logic [RF_AW-1:0] A_R0X = 4'd3;
	localparam logic [RF_AW-1:0] A_R0Z = 4'd4;
	localparam logic [RF_AW-1:0] A_R1X = 4'd5;
	localparam logic [RF_AW-1:0] A_R1Z = 4'd6;

	// raw sources of a reduce operation
	localparam logic [RF_AW-1:0] RAW_BX = 4'd0;
	localparam logic [RF_AW-1:0] RAW_BZ = 4'd1;
	localparam logic [RF_AW-1:0] RAW_D  = 4'd2;

	// program layout
	localparam int PC_W = 6;
	localparam logic [PC_W-1:0] PC_INIT_LAST    = 6'd15;
	localparam logic [PC_W-1:0] PC_LADDER_FIRST = 6'd16;
	localparam logic [PC_W-1:0] PC_PROG_LAST    = 6'd38;

	// control of the cell row as seen from the sequencer
	typedef struct packed {
		logic dbl;
		logic sub;
		logic cin;
		logic clr;
		logic en;
	} row_ctl_t;

	// control broadcast to every cell
	typedef struct packed {
		logic dbl;
		logic sub;
		logic sel1;
		logic cond;
		logic clr;
		logic en;
	} cell_ctl_t;

	function automatic uop_t mk(op_t op, logic [RF_AW-1:0] dst,
			logic [RF_AW-1:0] sa, logic [RF_AW-1:0] sb);
		uop_t u;
		u.op  = op;
		u.dst = dst;
		u.sa  = sa;
		u.sb  = sb;
		return u;
	endfunction

	// doubling of the PD point
	function automatic uop_t dbl_uop(logic [3:0] j);
		uop_t u;
		case (j)
			4'd0:    u = mk(OP_ADD, A_T0,  A_PDX, A_PDZ);
			4'd1:    u = mk(OP_SUB, A_T1,  A_PDX, A_PDZ);
			4'd2:    u = mk(OP_MUL, A_T0,  A_T0,  A_T0);
			4'd3:    u = mk(OP_MUL, A_T1,  A_T1,  A_T1);
			4'd4:    u = mk(OP_SUB, A_T2,  A_T0,  A_T1);
			4'd5:    u = mk(OP_MUL, A_PDX, A_T0,  A_T1);
			4'd6:    u = mk(OP_MUL, A_T3,  A_T2,  A_D);
			4'd7:    u = mk(OP_ADD, A_T3,  A_T3,  A_T1);
			default: u = mk(OP_MUL, A_PDZ, A_T2,  A_T3);
		endcase
		return u;
	endfunction

	// full microprogram: set-up, first doubling, one ladder step
	function automatic uop_t prog_uop(logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = mk(OP_RED, A_BX,  RAW_BX, A_BX);
			6'd1:  u = mk(OP_RED, A_BZ,  RAW_BZ, A_BX);
			6'd2:  u = mk(OP_RED, A_D,   RAW_D,  A_BX);
			6'd3:  u = mk(OP_CPY, A_PDX, A_BX,   A_BX);
			6'd4:  u = mk(OP_CPY, A_PDZ, A_BZ,   A_BX);
			6'd5:  u = mk(OP_CPY, A_PSX, A_BX,   A_BX);
			6'd6:  u = mk(OP_CPY, A_PSZ, A_BZ,   A_BX);
			6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15:
				u = dbl_uop(4'(pc - 6'd7));
			6'd16: u = mk(OP_ADD, A_T0,  A_PDX, A_PDZ);
			6'd17: u = mk(OP_SUB, A_T1,  A_PSX, A_PSZ);
			6'd18: u = mk(OP_MUL, A_T0,  A_T0,  A_T1);
			6'd19: u = mk(OP_SUB, A_T1,  A_PDX, A_PDZ);
			6'd20: u = mk(OP_ADD, A_T2,  A_PSX, A_PSZ);
			6'd21: u = mk(OP_MUL, A_T1,  A_T1,  A_T2);
			6'd22: u = mk(OP_ADD, A_T2,  A_T0,  A_T1);
			6'd23: u = mk(OP_SUB, A_T3,  A_T0,  A_T1);
			6'd24: u = mk(OP_MUL, A_T2,  A_T2,  A_T2);
			6'd25: u = mk(OP_MUL, A_T3,  A_T3,  A_T3);
			6'd26: u = mk(OP_MUL, A_T4,  A_BZ,  A_T2);
			6'd27: u = mk(OP_MUL, A_T5,  A_BX,  A_T3);
			6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36:
				u = dbl_uop(4'(pc - 6'd28));
			6'd37: u = mk(OP_CPY, A_PSX, A_T4,  A_BX);
			default: u = mk(OP_CPY, A_PSZ, A_T5, A_BX);
		endcase
		return u;
	endfunction

	// map the PD/PS pair onto R0/R1; sel set means R1 is doubled
	function automatic logic [RF_AW-1:0] map_addr(logic [RF_AW-1:0] a, logic sel);
		logic [RF_AW-1:0] p;
		p = a;
		if (sel) begin
			case (a)
				A_PDX:   p = A_R1X;
				A_PDZ:   p = A_R1Z;
				A_PSX:   p = A_R0X;
				A_PSZ:   p = A_R0Z;
				default: p = a;
			endcase
		end
		return p;
	endfunction

endpackage

FILE: design/mcl_ram.sv
// ----------------------------------------------------------------------------
// mcl_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module mcl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

FILE: design/mcl_cell.sv
// ----------------------------------------------------------------------------
// mcl_cell
// One slice of the modular accumulator: shift, reduce, add and fix-up chains.
// ----------------------------------------------------------------------------
module mcl_cell (
	input  logic                          clk,
	input  mcl_pkg::cell_ctl_t            ctl,
	input  logic [mcl_pkg::CELL_W-1:0]    x,
	input  logic [mcl_pkg::CELL_W-1:0]    y,
	input  logic [mcl_pkg::CELL_W-1:0]    n,
	input  logic                          shin,
	input  logic                          c1in,
	input  logic                          c2in,
	input  logic                          c3in,
	output logic                          shout,
	output logic                          c1out,
	output logic                          c2out,
	output logic                          c3out,
	output logic [mcl_pkg::CELL_W-1:0]    r
);
	import mcl_pkg::*;

	logic [CELL_W-1:0] r_q;
	logic [CELL_W-1:0] p, d1, r1, y2, s2, n3, d2;

	// first operand: doubled accumulator or loaded value, then less n
	always_comb begin
		p = ctl.dbl ? {r_q[CELL_W-2:0], shin} : x;
		{c1out, d1} = {1'b0, p} + {1'b0, ~n} + (CELL_W+1)'(c1in);
		r1 = ctl.sel1 ? d1 : p;
	end

	// add or subtract the second operand, then the fix-up by n
	always_comb begin
		y2 = ctl.sub ? ~y : y;
		{c2out, s2} = {1'b0, r1} + {1'b0, y2} + (CELL_W+1)'(c2in);
		n3 = ctl.sub ? n : ~n;
		{c3out, d2} = {1'b0, s2} + {1'b0, n3} + (CELL_W+1)'(c3in);
	end

	// accumulator slice
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			r_q <= '0;
		end else if (ctl.en) begin
			r_q <= ctl.cond ? d2 : s2;
		end
	end

	assign shout = r_q[CELL_W-1];
	assign r     = r_q;
endmodule

FILE: design/mcl_row.sv
// ----------------------------------------------------------------------------
// mcl_row
// Row of slice cells forming the modular add, subtract and shift-add unit.
// ----------------------------------------------------------------------------
module mcl_row #(
	parameter int MW = 64
) (
	input  logic              clk,
	input  mcl_pkg::row_ctl_t ctl,
	input  logic [MW-1:0]     x,
	input  logic [MW-1:0]     y,
	input  logic [MW-1:0]     n,
	output logic [MW-1:0]     r
);
	import mcl_pkg::*;

	localparam int NC = (MW + CELL_W - 1) / CELL_W;
	localparam int PW = NC * CELL_W;

	logic [PW-1:0] xp, yp, np, rp;
	logic [NC:0]   sh, c1, c2, c3;
	logic          sel1, cond;
	cell_ctl_t     cc;

	// pad operands to whole cells
	assign xp = PW'(x);
	assign yp = PW'(y);
	assign np = PW'(n);
	assign r  = rp[MW-1:0];

	// chain inputs at the low end
	assign sh[0] = ctl.cin;
	assign c1[0] = 1'b1;
	assign c2[0] = ctl.sub;
	assign c3[0] = ~ctl.sub;

	// selects from the top of the chains
	assign sel1 = (ctl.dbl & sh[NC]) | c1[NC];
	assign cond = ctl.sub ? ~c2[NC] : (c2[NC] | c3[NC]);
	assign cc   = '{dbl: ctl.dbl, sub: ctl.sub, sel1: sel1, cond: cond,
	                clr: ctl.clr, en: ctl.en};

	// the cells
	for (genvar g = 0; g < NC; g++) begin : g_cell
		mcl_cell u_cell (
			.clk   (clk),
			.ctl   (cc),
			.x     (xp[g*CELL_W +: CELL_W]),
			.y     (yp[g*CELL_W +: CELL_W]),
			.n     (np[g*CELL_W +: CELL_W]),
			.shin  (sh[g]),
			.c1in  (c1[g]),
			.c2in  (c2[g]),
			.c3in  (c3[g]),
			.shout (sh[g+1]),
			.c1out (c1[g+1]),
			.c2out (c2[g+1]),
			.c3out (c3[g+1]),
			.r     (rp[g*CELL_W +: CELL_W])
		);
	end
endmodule

FILE: design/montgomery_curve_ladder_scalar_mult.sv
// ----------------------------------------------------------------------------
// montgomery_curve_ladder_scalar_mult
// x:z Montgomery ladder scalar multiplication modulo a configured modulus.
// ----------------------------------------------------------------------------
// Usage:
// - input channel (in_valid/in_ready) moves base_x, base_z, scalar; output
//   channel (out_valid/out_ready) moves result_x, result_z, scalar_invalid
// - modulus and curve_d are set on the write port (cfg_we, cfg_index,
//   cfg_data) while the block is idle; reset loads modulus 3, curve_d 0
// - one item at a time: in_ready is high only while no item is in work
// - every micro-operation runs on one row of slice cells, framed by issue,
//   load and write-back; a multiply or a reduce takes 64 shift-add steps
// - sequence: find the top bit of k-1, set-up and first doubling, one ladder
//   step per remaining bit, then read out of R1
// - scalar below 2 or modulus below 2 goes straight to S_DONE, result zero
// - a stalled receiver holds the result in the output register; the next
//   item is taken while it waits, and its result waits until the slot frees
// - reset clears the sequencer and the output valid at once
// ----------------------------------------------------------------------------
module montgomery_curve_ladder_scalar_mult #(
	parameter int MOD_WIDTH   = 64,
	parameter int SCALAR_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] base_x,
	input  logic [63:0] base_z,
	input  logic [63:0] scalar,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_x,
	output logic [63:0] result_z,
	output logic        scalar_invalid
);
	import mcl_pkg::*;
	`include "montgomery_curve_ladder_scalar_mult_macros.svh"

	localparam int MW = MOD_WIDTH;
	localparam int SB = SCALAR_BITS;
	localparam int BW = $clog2(SB);

	localparam logic CFG_MODULUS = 1'b0;
	localparam logic CFG_CURVE_D = 1'b1;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_NORM  = 9'b000000010,
		S_ISSUE = 9'b000000100,
		S_LOAD  = 9'b000001000,
		S_EXEC  = 9'b000010000,
		S_WB    = 9'b000100000,
		S_FREAD = 9'b001000000,
		S_FCAP  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t           state_q;
	logic [63:0]      modulus_q, curve_d_q;
	logic [63:0]      bx_q, bz_q;
	logic [PC_W-1:0]  pc_q;
	logic             sel_q;
	logic [SB-1:0]    m_q;
	logic [BW-1:0]    bits_q;
	logic [STEP_W-1:0] cnt_q;
	logic [MW-1:0]    a_q;
	logic [RAW_W-1:0] b_q;
	logic [MW-1:0]    res_x_q, res_z_q;
	logic             res_inv_q;
	logic             out_valid_q;
	logic [63:0]      out_x_q, out_z_q;
	logic             out_inv_q;

	logic [MW-1:0]    n;
	logic [SB-1:0]    k;
	logic             k_lt2, n_lt2, in_xfer, out_load, sect_end;
	uop_t             uop;
	row_ctl_t         rctl;
	logic [MW-1:0]    row_x, row_y, row_r;
	logic [RF_AW-1:0] raddr_a, raddr_b, waddr;
	logic [MW-1:0]    rdata_a, rdata_b;
	logic [RAW_W-1:0] raw_src;

	assign n       = modulus_q[MW-1:0];
	assign k       = scalar[SB-1:0];
	assign k_lt2   = (k[SB-1:1] == '0);
	assign n_lt2   = (n[MW-1:1] == '0);
	assign in_ready = (state_q == S_IDLE);
	assign in_xfer = in_valid & in_ready;
	assign out_load = (state_q == S_DONE) & (~out_valid_q | out_ready);
	assign uop     = prog_uop(pc_q);
	assign sect_end = (pc_q == PC_INIT_LAST) | (pc_q == PC_PROG_LAST);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= 64'd3;
			curve_d_q <= 64'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODULUS: modulus_q <= cfg_data;
				CFG_CURVE_D: curve_d_q <= cfg_data;
				default:     modulus_q <= modulus_q;
			endcase
		end
	end

	// raw operand of a reduce
	always_comb begin
		unique case (uop.sa)
			RAW_BX:  raw_src = bx_q;
			RAW_BZ:  raw_src = bz_q;
			default: raw_src = curve_d_q;
		endcase
	end

	// operand store addressing
	always_comb begin
		if (state_q == S_FREAD) begin
			raddr_a = A_R1X;
			raddr_b = A_R1Z;
		end else begin
			raddr_a = map_addr(uop.sa, sel_q);
			raddr_b = map_addr(uop.sb, sel_q);
		end
		waddr = map_addr(uop.dst, sel_q);
	end

	mcl_ram #(
		.WIDTH (MW),
		.DEPTH (RF_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (state_q == S_WB),
		.waddr   (waddr),
		.wdata   (row_r),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// cell row control per micro-operation
	always_comb begin
		rctl     = '0;
		rctl.clr = (state_q == S_LOAD);
		rctl.en  = (state_q == S_EXEC);
		row_x    = a_q;
		row_y    = '0;
		case (uop.op)
			OP_MUL: begin
				rctl.dbl = 1'b1;
				row_y    = b_q[RAW_W-1] ? a_q : '0;
			end
			OP_RED: begin
				rctl.dbl = 1'b1;
				rctl.cin = b_q[RAW_W-1];
			end
			OP_ADD: row_y = b_q[MW-1:0];
			OP_SUB: begin
				rctl.sub = 1'b1;
				row_y    = b_q[MW-1:0];
			end
			default: row_y = '0;
		endcase
	end

	mcl_row #(
		.MW (MW)
	) u_row (
		.clk (clk),
		.ctl (rctl),
		.x   (row_x),
		.y   (row_y),
		.n   (n),
		.r   (row_r)
	);

	// operand and ladder registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					bx_q      <= base_x;
					bz_q      <= base_z;
					m_q       <= k - SB'(1);
					bits_q    <= BW'(SB - 1);
					res_x_q   <= '0;
					res_z_q   <= '0;
					res_inv_q <= k_lt2;
				end
			end
			S_NORM: begin
				if (!m_q[SB-1]) begin
					m_q    <= m_q << 1;
					bits_q <= bits_q - BW'(1);
				end
			end
			S_LOAD: begin
				a_q   <= rdata_a;
				b_q   <= (uop.op == OP_RED) ? raw_src : RAW_W'(rdata_b);
				cnt_q <= (uop.op == OP_RED || uop.op == OP_MUL) ? '1 : '0;
			end
			S_EXEC: begin
				b_q   <= b_q << 1;
				cnt_q <= cnt_q - STEP_W'(1);
			end
			S_WB: begin
				if (sect_end && bits_q != '0) begin
					m_q    <= m_q << 1;
					bits_q <= bits_q - BW'(1);
				end
			end
			S_FCAP: begin
				res_x_q   <= rdata_a;
				res_z_q   <= rdata_b;
				res_inv_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			sel_q   <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= (k_lt2 || n_lt2) ? S_DONE : S_NORM;
					end
				end
				S_NORM: begin
					if (m_q[SB-1]) begin
						pc_q    <= '0;
						sel_q   <= 1'b1;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_LOAD;
				S_LOAD:  state_q <= S_EXEC;
				S_EXEC: begin
					if (cnt_q == '0) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (!sect_end) begin
						pc_q    <= pc_q + PC_W'(1);
						state_q <= S_ISSUE;
					end else if (bits_q == '0) begin
						sel_q   <= 1'b1;
						state_q <= S_FREAD;
					end else begin
						sel_q   <= m_q[SB-2];
						pc_q    <= PC_LADDER_FIRST;
						state_q <= S_ISSUE;
					end
				end
				S_FREAD: state_q <= S_FCAP;
				S_FCAP:  state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q   <= 64'(res_x_q);
			out_z_q   <= 64'(res_z_q);
			out_inv_q <= res_inv_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_x       = out_x_q;
	assign result_z       = out_z_q;
	assign scalar_invalid = out_inv_q;

	// checks
	`MCL_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
	`MCL_ASSERT_IMP(a_res_x_reduced, out_valid && !n_lt2, result_x < 64'(n))
	`MCL_ASSERT_IMP(a_res_z_reduced, out_valid && !n_lt2, result_z < 64'(n))
	`MCL_ASSERT_IMP(a_invalid_zero, out_valid && scalar_invalid,
		result_x == 64'd0 && result_z == 64'd0)
endmodule

FILE: bench/montgomery_curve_ladder_scalar_mult_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// montgomery_curve_ladder_scalar_mult_tb
// Self-checking bench for the x:z Montgomery ladder. A directed table covers
// invalid scalars, degenerate, even and full-width moduli and unreduced
// operands; random phases with fresh modulus and curve constant follow. Every
// result is matched in transfer order to its typed row or a ladder predictor.
// ----------------------------------------------------------------------------
module montgomery_curve_ladder_scalar_mult_tb;

	localparam logic REG_MODULUS = 1'b0;
	localparam logic REG_CURVE_D = 1'b1;
	localparam logic [63:0] ALL_ONES = '1;

	typedef struct {
		logic [63:0] x;
		logic [63:0] z;
	} xz_t;

	typedef struct {
		logic [63:0] x;
		logic [63:0] z;
		logic        inv;
	} ladder_res_t;

	typedef struct {
		bit          is_cfg;
		logic        reg_idx;
		logic [63:0] bx;
		logic [63:0] bz;
		logic [63:0] k;
		bit          typed;
		ladder_res_t res;
	} vec_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] base_x;
	logic [63:0] base_z;
	logic [63:0] scalar;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] result_x;
	logic [63:0] result_z;
	logic        scalar_invalid;

	logic [63:0] cur_modulus;
	logic [63:0] cur_d;
	ladder_res_t pending_q[$];
	int          n_errors;
	int          n_items;
	int          n_results;
	int          n_settings;
	int          n_long;
	bit          quiet;
	bit          hold_req;

	montgomery_curve_ladder_scalar_mult u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.base_x(base_x), .base_z(base_z), .scalar(scalar),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_x(result_x), .result_z(result_z), .scalar_invalid(scalar_invalid)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// modular helpers; the multiply uses a 128-bit intermediate, the add a 65-bit sum
	function automatic logic [63:0] m_add(logic [63:0] a, logic [63:0] b, logic [63:0] n);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return 64'(s % {1'b0, n});
	endfunction

	function automatic logic [63:0] m_sub(logic [63:0] a, logic [63:0] b, logic [63:0] n);
		return (a >= b) ? a - b : a + (n - b);
	endfunction

	function automatic logic [63:0] m_mul(logic [63:0] a, logic [63:0] b, logic [63:0] n);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p % {64'd0, n});
	endfunction

	function automatic xz_t pt_double(xz_t p, logic [63:0] d, logic [63:0] n);
		logic [63:0] u, v, df, t;
		xz_t r;
		u = m_mul(m_add(p.x, p.z, n), m_add(p.x, p.z, n), n);
		v = m_mul(m_sub(p.x, p.z, n), m_sub(p.x, p.z, n), n);
		df = m_sub(u, v, n);
		t = m_add(m_mul(df, d, n), v, n);
		r.x = m_mul(u, v, n);
		r.z = m_mul(df, t, n);
		return r;
	endfunction

	function automatic xz_t pt_diff_add(xz_t p, xz_t q, xz_t b, logic [63:0] n);
		logic [63:0] s, m, w, t;
		xz_t r;
		s = m_mul(m_add(p.x, p.z, n), m_sub(q.x, q.z, n), n);
		m = m_mul(m_sub(p.x, p.z, n), m_add(q.x, q.z, n), n);
		w = m_add(s, m, n);
		t = m_sub(s, m, n);
		r.x = m_mul(b.z, m_mul(w, w, n), n);
		r.z = m_mul(b.x, m_mul(t, t, n), n);
		return r;
	endfunction

	// k times (bx:bz) under the current modulus and curve constant
	function automatic ladder_res_t ladder_mult(logic [63:0] bx, logic [63:0] bz,
			logic [63:0] k);
		ladder_res_t res;
		logic [63:0] n, d, m;
		xz_t b, r0, r1, sum;
		int top;
		n = cur_modulus;
		res.x = '0;
		res.z = '0;
		res.inv = (k < 2);
		if (k < 2 || n < 2)
			return res;
		d = cur_d % n;
		b.x = bx % n;
		b.z = bz % n;
		m = k - 1;
		top = 63;
		while (top > 0 && !m[top])
			top--;
		r0 = b;
		r1 = pt_double(b, d, n);
		for (int i = top - 1; i >= 0; i--) begin
			sum = pt_diff_add(r0, r1, b, n);
			if (m[i]) begin
				r1 = pt_double(r1, d, n);
				r0 = sum;
			end else begin
				r0 = pt_double(r0, d, n);
				r1 = sum;
			end
		end
		res.x = r1.x;
		res.z = r1.z;
		return res;
	endfunction

	// register write, only once the block has drained
	task automatic write_reg(logic idx, logic [63:0] data);
		in_valid <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (10) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MODULUS)
			cur_modulus = data;
		else
			cur_d = data;
		n_settings++;
	endtask

	// offer one item and hold it until the transfer
	task automatic send_item(logic [63:0] bx, logic [63:0] bz, logic [63:0] k,
			bit typed, ladder_res_t res);
		int gap;
		in_valid <= 1'b1;
		base_x   <= bx;
		base_z   <= bz;
		scalar   <= k;
		do
			@(posedge clk);
		while (!in_ready);
		pending_q.push_back(typed ? res : ladder_mult(bx, bz, k));
		n_items++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// receiver: random stalls, one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		ladder_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$error("result transfer with nothing expected");
				n_errors++;
			end else begin
				e = pending_q.pop_front();
				n_results++;
				if (result_x !== e.x) begin
					$error("result_x expected %h actual %h", e.x, result_x);
					n_errors++;
				end
				if (result_z !== e.z) begin
					$error("result_z expected %h actual %h", e.z, result_z);
					n_errors++;
				end
				if (scalar_invalid !== e.inv) begin
					$error("scalar_invalid expected %b actual %b", e.inv, scalar_invalid);
					n_errors++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// stimulus
	initial begin
		vec_t dir_tab[$];
		vec_t v;
		ladder_res_t z0, z1;
		logic [63:0] k;
		int r, drain;

		cfg_we    <= 1'b0;
		cfg_index <= REG_MODULUS;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		base_x    <= '0;
		base_z    <= '0;
		scalar    <= '0;
		out_ready <= 1'b0;
		arst_n    <= 1'b0;
		n_errors = 0; n_items = 0; n_results = 0; n_settings = 0; n_long = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		cur_modulus = 64'd3;
		cur_d = 64'd0;
		z0 = '{x: '0, z: '0, inv: 1'b0};
		z1 = '{x: '0, z: '0, inv: 1'b1};

		// directed table; config rows carry the value in bx
		dir_tab = '{
			'{0, REG_MODULUS, 64'd0, 64'd0, 64'd0, 1, z1},
			'{0, REG_MODULUS, ALL_ONES, ALL_ONES, 64'd1, 1, z1},
			'{0, REG_MODULUS, 64'd1, 64'd1, 64'd2, 0, z0},
			'{0, REG_MODULUS, ALL_ONES, 64'd2, ALL_ONES, 0, z0},
			'{1, REG_MODULUS, 64'd0, 64'd0, 64'd0, 0, z0},
			'{0, REG_MODULUS, 64'd5, 64'd7, 64'd9, 1, z0},
			'{0, REG_MODULUS, 64'd5, 64'd7, 64'd0, 1, z1},
			'{1, REG_MODULUS, 64'd1, 64'd0, 64'd0, 0, z0},
			'{0, REG_MODULUS, 64'd5, 64'd7, 64'd100, 1, z0},
			'{1, REG_MODULUS, ALL_ONES, 64'd0, 64'd0, 0, z0},
			'{1, REG_CURVE_D, ALL_ONES, 64'd0, 64'd0, 0, z0},
			'{0, REG_MODULUS, ALL_ONES - 1, 64'd1, 64'd3, 0, z0},
			'{0, REG_MODULUS, ALL_ONES, ALL_ONES, 64'd2, 0, z0},
			'{0, REG_MODULUS, 64'd2, 64'd1, 64'h5555_5555_5555_5555, 0, z0},
			'{1, REG_MODULUS, 64'd1000, 64'd0, 64'd0, 0, z0},
			'{1, REG_CURVE_D, 64'd7, 64'd0, 64'd0, 0, z0},
			'{0, REG_MODULUS, 64'd3, 64'd1, 64'd10, 0, z0},
			'{0, REG_MODULUS, 64'd1234567, 64'd89, 64'd255, 0, z0},
			'{1, REG_MODULUS, 64'd1000003, 64'd0, 64'd0, 0, z0},
			'{1, REG_CURVE_D, 64'd2000000, 64'd0, 64'd0, 0, z0},
			'{0, REG_MODULUS, 64'd2, 64'd1, 64'd17, 0, z0},
			'{0, REG_MODULUS, 64'd0, 64'd0, 64'd20, 0, z0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (dir_tab[i]) begin
			v = dir_tab[i];
			if (v.is_cfg)
				write_reg(v.reg_idx, v.bx);
			else
				send_item(v.bx, v.bz, v.k, v.typed, v.res);
		end

		// random phases, each with a fresh modulus and curve constant
		for (int ph = 0; ph < 8; ph++) begin
			if ($urandom_range(0, 1))
				write_reg(REG_MODULUS, 64'($urandom_range(3, 65535)) | 64'd1);
			else
				write_reg(REG_MODULUS, {$urandom, $urandom} | 64'd1);
			write_reg(REG_CURVE_D, {$urandom, $urandom});

			// long receiver hold while invalid scalars fill the block
			if (ph == 3) begin
				hold_req = 1'b1;
				for (int j = 0; j < 4; j++)
					send_item({$urandom, $urandom}, {$urandom, $urandom}, 64'd0, 0, z0);
			end

			for (int j = 0; j < 12; j++) begin
				quiet = (ph == 7);
				r = $urandom_range(0, 99);
				if (r < 8)
					k = 64'($urandom_range(0, 1));
				else if (r < 96 || n_long >= 4)
					k = 64'($urandom_range(2, 255));
				else begin
					k = {$urandom, $urandom};
					n_long++;
				end
				send_item({$urandom, $urandom}, {$urandom, $urandom}, k, 0, z0);
			end
		end
		in_valid <= 1'b0;

		// drain
		wait (pending_q.size() == 0);
		repeat (50) @(posedge clk);
		drain = pending_q.size();
		$display("covered %0d items, %0d results checked, %0d register writes",
			n_items, n_results, n_settings);
		$display("including degenerate, even and full-width moduli and %0d long scalars",
			n_long + 2);
		if (n_errors == 0 && drain == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/mcl_pkg.sv
design/mcl_ram.sv
design/mcl_cell.sv
design/mcl_row.sv
design/montgomery_curve_ladder_scalar_mult.sv
bench/montgomery_curve_ladder_scalar_mult_tb.sv
